// ===== rtl/kvls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_pkg
// Shared constants for the key/value log store.
// ----------------------------------------------------------------------------
package kvls_pkg;

  // input function codes
  localparam logic [2:0] FN_BUS_RD  = 3'd0;
  localparam logic [2:0] FN_BUS_WR  = 3'd1;
  localparam logic [2:0] FN_KEY     = 3'd2;
  localparam logic [2:0] FN_VALUE   = 3'd3;
  localparam logic [2:0] FN_LOOKUP  = 3'd4;

  // set phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WRITE   = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  // result kinds
  localparam logic KIND_BUS    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // record type of a string record
  localparam logic [7:0] REC_STRING = 8'd1;

  // longest key kept
  localparam int unsigned KEY_MAX = 255;

  // width of internal byte addresses (covers 32-bit pointer plus record size)
  localparam int unsigned ADDR_W = 34;

  // header signature bytes
  localparam logic [7:0] SIG_BYTE [4] = '{8'h4E, 8'h56, 8'h52, 8'h4D};

endpackage

// ===== rtl/key_value_log_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_log_store_top
// Append-only key/value record store in a byte-wide RAM with bus access.
// ----------------------------------------------------------------------------
// Usage:
//   Input items transfer when start is high and busy is low. Key items are
//   taken in idle and leave busy low; a later value byte passes through the
//   value-byte state. The first value item of a set reads the append pointer,
//   checks the fit, writes the header and copies the key before its byte.
//   The last value item reads the count and rewrites pointer and count.
//   A bus access moves one byte per cycle through the store RAM.
//   A lookup walks the records: it reads the pointer and count, then for
//   each record visited fetches the header, compares the key when the length
//   matches, and on a match reads the value in chunks of up to 8 bytes.
//   Results appear on the out_ ports for one cycle with out_valid high;
//   the receiver cannot stall. The cfg_ port sets the write-enable bit at
//   any edge.
//   After reset the store is initialized by a sweep over all STORE_BYTES
//   addresses with busy high.
// ----------------------------------------------------------------------------
module key_value_log_store_top #(
  parameter int unsigned STORE_BYTES  = 8192,
  parameter int unsigned OBJECT_START = 16,
  parameter int unsigned RETURN_MAX   = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_offset,
  input  logic [3:0]  in_access_size,
  input  logic [63:0] in_data_in,
  input  logic        in_has_byte,
  input  logic [15:0] in_value_len,
  input  logic        in_last,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  output logic        out_kind,
  output logic [63:0] out_data_out,
  output logic [3:0]  out_byte_count,
  output logic        out_found,
  output logic        out_last_res
);
  import kvls_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] SB = ADDR_W'(STORE_BYTES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_GATHER, S_WRITE, S_EMIT_RD,
    S_V_START, S_KCPY, S_V_BYTE, S_V_CNT,
    S_LK_P, S_LK_C, S_LK_LOOP, S_LK_HDR, S_KCMP, S_LK_CHUNK, S_LK_EMIT
  } state_t;

  // control registers
  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [8:0]        j_r, j_nxt;
  logic [7:0]        key_len_r, key_len_nxt;
  logic              key_open_r, key_open_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [31:0]       entry_base_r, entry_base_nxt;
  logic [15:0]       vcount_r, vcount_nxt;
  logic [15:0]       decl_r, decl_nxt;
  logic              wen_r, wen_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [ADDR_W-1:0] gaddr_r, gaddr_nxt;
  logic [3:0]        gcnt_r, gcnt_nxt;
  logic [63:0]       gdata_r, gdata_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;
  logic [3:0]        wcnt_r, wcnt_nxt;
  logic [63:0]       wbuf_r, wbuf_nxt;
  logic              hb_r, hb_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [15:0]       vlen_r, vlen_nxt;
  logic [31:0]       ptr_r, ptr_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [31:0]       i_r, i_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] vbase_r, vbase_nxt;
  logic [7:0]        kl_r, kl_nxt;
  logic [15:0]       vl_r, vl_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        pos_r, pos_nxt;
  logic [3:0]        chunk_r, chunk_nxt;
  logic              oob_r, oob_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic [3:0]        out_cnt_r, out_cnt_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;

  // memory ports
  logic              st_we;
  logic [ADDR_W-1:0] wr_full, rd_full;
  logic [7:0]        st_wdata, st_rdata, st_rbyte;
  logic              kb_we;
  logic [7:0]        kb_waddr, kb_wdata, kb_raddr, kb_rdata;

  // scratch
  logic              accept;
  logic [3:0]        n_bytes;
  logic [7:0]        klen;
  logic [ADDR_W-1:0] sum;
  logic [7:0]        rem;
  logic [8:0]        newpos;
  logic [2:0]        gidx;

  function automatic logic [7:0] init_byte(input logic [AW-1:0] a);
    logic [15:0] os;
    os = 16'(OBJECT_START);
    if (a < AW'(4)) begin
      init_byte = SIG_BYTE[a[1:0]];
    end else if (a == AW'(4)) begin
      init_byte = os[7:0];
    end else if (a == AW'(5)) begin
      init_byte = os[15:8];
    end else begin
      init_byte = 8'd0;
    end
  endfunction

  kvls_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk(clk), .we(st_we), .waddr(wr_full[AW-1:0]), .wdata(st_wdata),
    .raddr(rd_full[AW-1:0]), .rdata(st_rdata)
  );

  kvls_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_keybuf (
    .clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(kb_wdata),
    .raddr(kb_raddr), .rdata(kb_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign st_rbyte  = oob_r ? 8'd0 : st_rdata;
  assign n_bytes   = (in_access_size > 4'd8) ? 4'd8 : in_access_size;
  assign klen      = key_open_r ? key_len_r : 8'd0;
  assign gidx      = 3'(k_r - 4'd1);
  assign rem       = len_r - pos_r;
  assign newpos    = {1'b0, pos_r} + {5'd0, chunk_r};
  assign sum       = ADDR_W'(gdata_r[31:0]) + ADDR_W'(4) + ADDR_W'(key_len_r)
                   + ADDR_W'(vlen_r);

  // next-state logic
  always_comb begin
    state_nxt = state_r;       ret_nxt = ret_r;           clr_nxt = clr_r;
    k_nxt = k_r;               j_nxt = j_r;               key_len_nxt = key_len_r;
    key_open_nxt = key_open_r; phase_nxt = phase_r;       entry_base_nxt = entry_base_r;
    vcount_nxt = vcount_r;     decl_nxt = decl_r;         out_valid_nxt = 1'b0;
    wen_nxt = cfg_we ? cfg_wdata : wen_r;
    gaddr_nxt = gaddr_r;       gcnt_nxt = gcnt_r;         gdata_nxt = gdata_r;
    waddr_nxt = waddr_r;       wcnt_nxt = wcnt_r;         wbuf_nxt = wbuf_r;
    hb_nxt = hb_r;             byte_nxt = byte_r;         last_nxt = last_r;
    vlen_nxt = vlen_r;         ptr_nxt = ptr_r;           cnt_nxt = cnt_r;
    i_nxt = i_r;               cur_nxt = cur_r;           end_nxt = end_r;
    vbase_nxt = vbase_r;       kl_nxt = kl_r;             vl_nxt = vl_r;
    len_nxt = len_r;           pos_nxt = pos_r;           chunk_nxt = chunk_r;
    out_kind_nxt = out_kind_r; out_data_nxt = out_data_r; out_cnt_nxt = out_cnt_r;
    out_found_nxt = out_found_r; out_last_nxt = out_last_r;
    st_we = 1'b0; wr_full = '0; st_wdata = 8'd0; rd_full = '0;
    kb_we = 1'b0; kb_waddr = 8'd0; kb_wdata = 8'd0; kb_raddr = 8'd0;

    case (state_r)
      // initialization sweep over the store
      S_CLEAR: begin
        wr_full  = ADDR_W'(clr_r);
        st_we    = 1'b1;
        st_wdata = init_byte(clr_r);
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          hb_nxt   = in_has_byte;
          byte_nxt = in_data_in[7:0];
          last_nxt = in_last;
          vlen_nxt = in_value_len;
          k_nxt    = 4'd0;
          case (in_func)
            FN_BUS_RD: begin
              gaddr_nxt = ADDR_W'(in_offset);
              gcnt_nxt  = (ADDR_W'(in_offset) < SB) ? n_bytes : 4'd0;
              gdata_nxt = 64'd0;
              ret_nxt   = S_EMIT_RD;
              state_nxt = S_GATHER;
            end
            FN_BUS_WR: begin
              if ((ADDR_W'(in_offset) < SB) && wen_r) begin
                waddr_nxt = ADDR_W'(in_offset);
                wcnt_nxt  = n_bytes;
                wbuf_nxt  = in_data_in;
                ret_nxt   = S_IDLE;
                state_nxt = S_WRITE;
              end
            end
            FN_KEY: begin
              phase_nxt   = PH_IDLE;
              key_len_nxt = klen;
              if (in_has_byte && (klen < 8'(KEY_MAX))) begin
                kb_we       = 1'b1;
                kb_waddr    = klen;
                kb_wdata    = in_data_in[7:0];
                key_len_nxt = klen + 8'd1;
              end
              key_open_nxt = !in_last;
            end
            FN_VALUE: begin
              key_open_nxt = 1'b0;
              if (phase_r == PH_IDLE) begin
                gaddr_nxt = ADDR_W'(4);
                gcnt_nxt  = 4'd4;
                gdata_nxt = 64'd0;
                ret_nxt   = S_V_START;
                state_nxt = S_GATHER;
              end else begin
                state_nxt = S_V_BYTE;
              end
            end
            FN_LOOKUP: begin
              key_open_nxt = 1'b0;
              gaddr_nxt = ADDR_W'(4);
              gcnt_nxt  = 4'd4;
              gdata_nxt = 64'd0;
              ret_nxt   = S_LK_P;
              state_nxt = S_GATHER;
            end
            default: ;
          endcase
        end
      end

      // pipelined byte reads into gdata, little-endian
      S_GATHER: begin
        if (k_r < gcnt_r) begin
          rd_full = gaddr_r + ADDR_W'(k_r);
        end
        if (k_r != 4'd0) begin
          gdata_nxt[{gidx, 3'b000} +: 8] = st_rbyte;
        end
        if (k_r == gcnt_r) begin
          k_nxt     = 4'd0;
          state_nxt = ret_r;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end

      // byte writes from wbuf, dropped past the end
      S_WRITE: begin
        if (k_r == wcnt_r) begin
          k_nxt     = 4'd0;
          state_nxt = ret_r;
        end else begin
          wr_full  = waddr_r + ADDR_W'(k_r);
          st_we    = (wr_full < SB);
          st_wdata = wbuf_r[{k_r[2:0], 3'b000} +: 8];
          k_nxt    = k_r + 4'd1;
        end
      end

      S_EMIT_RD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_BUS;
        out_data_nxt  = gdata_r;
        out_cnt_nxt   = 4'd0;
        out_found_nxt = 1'b0;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end

      // first value item: write-enable and fit check, then header
      S_V_START: begin
        decl_nxt   = vlen_r;
        vcount_nxt = 16'd0;
        if (!wen_r || (sum > SB)) begin
          phase_nxt = PH_DISCARD;
          state_nxt = S_V_BYTE;
        end else begin
          entry_base_nxt = gdata_r[31:0];
          wbuf_nxt  = {32'd0, vlen_r[15:8], vlen_r[7:0], key_len_r, REC_STRING};
          waddr_nxt = ADDR_W'(gdata_r[31:0]);
          wcnt_nxt  = 4'd4;
          j_nxt     = 9'd0;
          ret_nxt   = S_KCPY;
          state_nxt = S_WRITE;
        end
      end

      // copy key buffer behind the header
      S_KCPY: begin
        if (j_r < {1'b0, key_len_r}) begin
          kb_raddr = j_r[7:0];
        end
        if (j_r != 9'd0) begin
          wr_full  = ADDR_W'(entry_base_r) + ADDR_W'(3) + ADDR_W'(j_r);
          st_we    = (wr_full < SB);
          st_wdata = kb_rdata;
        end
        if (j_r == {1'b0, key_len_r}) begin
          phase_nxt = PH_WRITE;
          state_nxt = S_V_BYTE;
        end else begin
          j_nxt = j_r + 9'd1;
        end
      end

      S_V_BYTE: begin
        state_nxt = S_IDLE;
        if ((phase_r == PH_WRITE) && hb_r && (vcount_r < decl_r)) begin
          wr_full    = ADDR_W'(entry_base_r) + ADDR_W'(4) + ADDR_W'(key_len_r)
                     + ADDR_W'(vcount_r);
          st_we      = (wr_full < SB);
          st_wdata   = byte_r;
          vcount_nxt = vcount_r + 16'd1;
        end
        if (last_r) begin
          if (phase_r == PH_WRITE) begin
            gaddr_nxt = ADDR_W'(8);
            gcnt_nxt  = 4'd4;
            gdata_nxt = 64'd0;
            k_nxt     = 4'd0;
            ret_nxt   = S_V_CNT;
            state_nxt = S_GATHER;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end

      // commit: pointer at 4..7 and count at 8..11 in one sweep
      S_V_CNT: begin
        wbuf_nxt  = {gdata_r[31:0] + 32'd1,
                     entry_base_r + 32'd4 + 32'(key_len_r) + 32'(decl_r)};
        waddr_nxt = ADDR_W'(4);
        wcnt_nxt  = 4'd8;
        k_nxt     = 4'd0;
        phase_nxt = PH_IDLE;
        ret_nxt   = S_IDLE;
        state_nxt = S_WRITE;
      end

      S_LK_P: begin
        ptr_nxt   = gdata_r[31:0];
        gaddr_nxt = ADDR_W'(8);
        gcnt_nxt  = 4'd4;
        gdata_nxt = 64'd0;
        ret_nxt   = S_LK_C;
        state_nxt = S_GATHER;
      end

      S_LK_C: begin
        cnt_nxt   = gdata_r[31:0];
        cur_nxt   = ADDR_W'(OBJECT_START);
        i_nxt     = 32'd0;
        state_nxt = S_LK_LOOP;
      end

      // walk condition and record header fetch
      S_LK_LOOP: begin
        if ((i_r < cnt_r) && (cur_r < ADDR_W'(ptr_r)) && (cur_r < SB)) begin
          gaddr_nxt = cur_r;
          gcnt_nxt  = 4'd4;
          gdata_nxt = 64'd0;
          ret_nxt   = S_LK_HDR;
          state_nxt = S_GATHER;
        end else begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LOOKUP;
          out_data_nxt  = 64'd0;
          out_cnt_nxt   = 4'd0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_LK_HDR: begin
        kl_nxt  = gdata_r[15:8];
        vl_nxt  = gdata_r[31:16];
        end_nxt = cur_r + ADDR_W'(4) + ADDR_W'(gdata_r[15:8]) + ADDR_W'(gdata_r[31:16]);
        j_nxt   = 9'd0;
        if (end_nxt > ADDR_W'(ptr_r)) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LOOKUP;
          out_data_nxt  = 64'd0;
          out_cnt_nxt   = 4'd0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else if ((gdata_r[7:0] == REC_STRING) && (gdata_r[15:8] == key_len_r)) begin
          state_nxt = S_KCMP;
        end else begin
          cur_nxt   = end_nxt;
          i_nxt     = i_r + 32'd1;
          state_nxt = S_LK_LOOP;
        end
      end

      // byte compare of stored key against the key buffer
      S_KCMP: begin
        if (j_r < {1'b0, kl_r}) begin
          rd_full  = cur_r + ADDR_W'(4) + ADDR_W'(j_r);
          kb_raddr = j_r[7:0];
        end
        if ((j_r != 9'd0) && (st_rbyte != kb_rdata)) begin
          cur_nxt   = end_r;
          i_nxt     = i_r + 32'd1;
          state_nxt = S_LK_LOOP;
        end else if (j_r == {1'b0, kl_r}) begin
          len_nxt   = (vl_r < 16'(RETURN_MAX)) ? vl_r[7:0] : 8'(RETURN_MAX);
          pos_nxt   = 8'd0;
          vbase_nxt = cur_r + ADDR_W'(4) + ADDR_W'(kl_r);
          state_nxt = S_LK_CHUNK;
        end else begin
          j_nxt = j_r + 9'd1;
        end
      end

      S_LK_CHUNK: begin
        chunk_nxt = (rem < 8'd8) ? rem[3:0] : 4'd8;
        gaddr_nxt = vbase_r + ADDR_W'(pos_r);
        gcnt_nxt  = chunk_nxt;
        gdata_nxt = 64'd0;
        k_nxt     = 4'd0;
        ret_nxt   = S_LK_EMIT;
        state_nxt = S_GATHER;
      end

      S_LK_EMIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_LOOKUP;
        out_data_nxt  = gdata_r;
        out_cnt_nxt   = chunk_r;
        out_found_nxt = 1'b1;
        out_last_nxt  = (newpos >= {1'b0, len_r});
        pos_nxt       = newpos[7:0];
        state_nxt     = (newpos < {1'b0, len_r}) ? S_LK_CHUNK : S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // read address range flag travels with the registered read
  assign oob_nxt = (rd_full >= SB);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;     ret_r <= S_IDLE;      clr_r <= '0;
      k_r <= 4'd0;            j_r <= 9'd0;          key_len_r <= 8'd0;
      key_open_r <= 1'b0;     phase_r <= PH_IDLE;   entry_base_r <= 32'd0;
      vcount_r <= 16'd0;      decl_r <= 16'd0;      wen_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;   ret_r <= ret_nxt;     clr_r <= clr_nxt;
      k_r <= k_nxt;           j_r <= j_nxt;         key_len_r <= key_len_nxt;
      key_open_r <= key_open_nxt; phase_r <= phase_nxt; entry_base_r <= entry_base_nxt;
      vcount_r <= vcount_nxt; decl_r <= decl_nxt;   wen_r <= wen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    gaddr_r <= gaddr_nxt;  gcnt_r <= gcnt_nxt;   gdata_r <= gdata_nxt;
    waddr_r <= waddr_nxt;  wcnt_r <= wcnt_nxt;   wbuf_r <= wbuf_nxt;
    hb_r <= hb_nxt;        byte_r <= byte_nxt;   last_r <= last_nxt;
    vlen_r <= vlen_nxt;    ptr_r <= ptr_nxt;     cnt_r <= cnt_nxt;
    i_r <= i_nxt;          cur_r <= cur_nxt;     end_r <= end_nxt;
    vbase_r <= vbase_nxt;  kl_r <= kl_nxt;       vl_r <= vl_nxt;
    len_r <= len_nxt;      pos_r <= pos_nxt;     chunk_r <= chunk_nxt;
    oob_r <= oob_nxt;
    out_kind_r <= out_kind_nxt;   out_data_r <= out_data_nxt;
    out_cnt_r <= out_cnt_nxt;     out_found_r <= out_found_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_out   = out_data_r;
  assign out_byte_count = out_cnt_r;
  assign out_found      = out_found_r;
  assign out_last_res   = out_last_r;

endmodule

// ===== rtl/kvls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kvls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kvls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_checker
// Port-level checks on result framing of the key/value log store.
// ----------------------------------------------------------------------------
module kvls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_kind,
  input logic [63:0] out_data_out,
  input logic [3:0]  out_byte_count,
  input logic        out_found,
  input logic        out_last_res
);
  import kvls_pkg::*;

  // store init sweep follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // bus read result is a single plain transfer
  a_bus_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_BUS) |-> (out_last_res && !out_found &&
                                             out_byte_count == 4'd0))
    else $error("bad bus read result framing");

  // a miss is one empty final transfer
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_LOOKUP && !out_found) |->
      (out_last_res && out_byte_count == 4'd0 && out_data_out == 64'd0))
    else $error("bad not-found result");

  // only the final chunk may be short
  a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found && !out_last_res) |-> (out_byte_count == 4'd8))
    else $error("short non-final chunk");

endmodule

bind key_value_log_store_top kvls_checker u_kvls_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_kind(out_kind), .out_data_out(out_data_out),
  .out_byte_count(out_byte_count), .out_found(out_found),
  .out_last_res(out_last_res)
);

// ===== tb/tb_key_value_log_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_log_store_top
// Self-checking bench for the key/value log store. A scoreboard class keeps
// its own copy of the byte store, the key buffer and the set state. It
// predicts bus read data and lookup answers for every accepted transfer and
// checks each result strobe against the oldest prediction. A short directed
// part comes first, then random sets, lookups and bus traffic under three
// idling profiles, with write enable on, then off, then on again.
// ----------------------------------------------------------------------------
module tb_key_value_log_store_top;
  import kvls_pkg::*;

  localparam int unsigned STORE_BYTES  = 8192;
  localparam int unsigned OBJECT_START = 16;
  localparam int unsigned RETURN_MAX   = 255;
  localparam int unsigned STALL_LIMIT  = 100000;

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
    logic [3:0]  count;
    logic        found;
    logic        last;
  } kv_answer_t;

  // predicts answers of the store from accepted transfers
  class kv_scoreboard;
    logic [7:0]  mem [STORE_BYTES];
    logic [7:0]  kbuf [KEY_MAX];
    int unsigned klen;
    bit          kopen;
    logic [1:0]  phase;
    longint unsigned rec_base;
    int unsigned vcount;
    int unsigned dlen;
    bit          wen;
    kv_answer_t  pending [$];
    int          errors;
    int          answers;
    int          hits;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      foreach (SIG_BYTE[i]) mem[i] = SIG_BYTE[i];
      mem[4] = OBJECT_START[7:0];
      mem[5] = OBJECT_START[15:8];
      klen = 0; kopen = 0; phase = PH_IDLE; rec_base = 0;
      vcount = 0; dlen = 0; wen = 1; errors = 0; answers = 0; hits = 0;
    endfunction

    function longint unsigned rd8(longint unsigned a);
      return (a < STORE_BYTES) ? longint'(mem[a]) : 0;
    endfunction

    function longint unsigned rd32(longint unsigned a);
      return rd8(a) | (rd8(a + 1) << 8) | (rd8(a + 2) << 16) | (rd8(a + 3) << 24);
    endfunction

    function void wr8(longint unsigned a, longint unsigned v);
      if (a < STORE_BYTES) mem[a] = v[7:0];
    endfunction

    function void wr32(longint unsigned a, longint unsigned v);
      for (int i = 0; i < 4; i++) wr8(a + i, v >> (8 * i));
    endfunction

    function void push(logic kind, logic [63:0] d, int c, logic f, logic l);
      kv_answer_t r;
      r.kind = kind; r.data = d; r.count = c[3:0]; r.found = f; r.last = l;
      pending.push_back(r);
    endfunction

    // walk the records for the buffered key
    function void predict_lookup();
      longint unsigned ptr, cnt, cur, i, kl, vl, len, pos, c, vbase;
      logic [63:0] d;
      bit match;
      ptr = rd32(4); cnt = rd32(8); cur = OBJECT_START; i = 0;
      while (i < cnt && cur < ptr && cur < STORE_BYTES) begin
        kl = rd8(cur + 1);
        vl = rd8(cur + 2) | (rd8(cur + 3) << 8);
        if (cur + 4 + kl + vl > ptr) break;
        match = (rd8(cur) == REC_STRING) && (kl == klen);
        for (int j = 0; match && j < kl; j++)
          if (rd8(cur + 4 + j) != longint'(kbuf[j])) match = 0;
        if (match) begin
          len = (vl < RETURN_MAX) ? vl : RETURN_MAX;
          vbase = cur + 4 + kl;
          pos = 0;
          hits++;
          do begin
            c = (len - pos < 8) ? len - pos : 8;
            d = '0;
            for (int b = 0; b < c; b++) d |= rd8(vbase + pos + b) << (8 * b);
            pos += c;
            push(KIND_LOOKUP, d, int'(c), 1'b1, pos >= len);
          end while (pos < len);
          return;
        end
        cur += 4 + kl + vl;
        i++;
      end
      push(KIND_LOOKUP, '0, 0, 1'b0, 1'b1);
    endfunction

    // note one accepted input transfer
    function void note(logic [2:0] fn, logic [15:0] off, logic [3:0] sz,
                       logic [63:0] din, logic hb, logic [15:0] vlen, logic lst);
      int unsigned n;
      logic [63:0] d;
      longint unsigned b;
      n = (sz < 8) ? sz : 8;
      case (fn)
        FN_BUS_RD: begin
          d = '0;
          if (off < STORE_BYTES)
            for (int i = 0; i < n; i++) d |= rd8(off + i) << (8 * i);
          push(KIND_BUS, d, 0, 1'b0, 1'b1);
        end
        FN_BUS_WR: begin
          if (off < STORE_BYTES && wen)
            for (int i = 0; i < n; i++) wr8(off + i, din >> (8 * i));
        end
        FN_KEY: begin
          phase = PH_IDLE;
          if (!kopen) begin
            klen = 0;
            kopen = 1;
          end
          if (hb && klen < KEY_MAX) begin
            kbuf[klen] = din[7:0];
            klen++;
          end
          if (lst) kopen = 0;
        end
        FN_VALUE: begin
          kopen = 0;
          if (phase == PH_IDLE) begin
            b = rd32(4);
            dlen = vlen;
            vcount = 0;
            if (!wen || b + 4 + klen + dlen > STORE_BYTES) begin
              phase = PH_DISCARD;
            end else begin
              rec_base = b;
              wr8(b, REC_STRING);
              wr8(b + 1, klen);
              wr8(b + 2, dlen);
              wr8(b + 3, dlen >> 8);
              for (int i = 0; i < klen; i++) wr8(b + 4 + i, kbuf[i]);
              phase = PH_WRITE;
            end
          end
          if (phase == PH_WRITE && hb && vcount < dlen) begin
            wr8(rec_base + 4 + klen + vcount, din[7:0]);
            vcount++;
          end
          if (lst) begin
            if (phase == PH_WRITE) begin
              wr32(8, (rd32(8) + 1) & 32'hFFFF_FFFF);
              wr32(4, rec_base + 4 + klen + dlen);
            end
            phase = PH_IDLE;
          end
        end
        FN_LOOKUP: begin
          kopen = 0;
          predict_lookup();
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    // compare one result strobe with the oldest prediction
    task check(kv_answer_t r);
      kv_answer_t e;
      answers++;
      if (pending.size() == 0) begin
        report("unexpected result", r.data, '0);
        return;
      end
      e = pending.pop_front();
      if (r.kind  !== e.kind)  report("kind", r.kind, e.kind);
      if (r.data  !== e.data)  report("data_out", r.data, e.data);
      if (r.count !== e.count) report("byte_count", r.count, e.count);
      if (r.found !== e.found) report("found", r.found, e.found);
      if (r.last  !== e.last)  report("last_res", r.last, e.last);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_func = '0;
  logic [15:0] in_offset = '0;
  logic [3:0]  in_access_size = '0;
  logic [63:0] in_data_in = '0;
  logic        in_has_byte = 0;
  logic [15:0] in_value_len = '0;
  logic        in_last = 0;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        out_valid;
  logic        out_kind;
  logic [63:0] out_data_out;
  logic [3:0]  out_byte_count;
  logic        out_found;
  logic        out_last_res;

  kv_scoreboard sb = new();
  int          gap_pct = 0;
  int          items = 0;
  int          quiet = 0;
  logic [7:0]  key_pool [8][6];
  int          key_len_pool [8];

  key_value_log_store_top #(
    .STORE_BYTES (STORE_BYTES),
    .OBJECT_START(OBJECT_START),
    .RETURN_MAX  (RETURN_MAX)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_offset     (in_offset),
    .in_access_size(in_access_size),
    .in_data_in    (in_data_in),
    .in_has_byte   (in_has_byte),
    .in_value_len  (in_value_len),
    .in_last       (in_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_data_out  (out_data_out),
    .out_byte_count(out_byte_count),
    .out_found     (out_found),
    .out_last_res  (out_last_res)
  );

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check('{out_kind, out_data_out, out_byte_count, out_found, out_last_res});
  end

  // watchdog: cycles without any transfer or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one input transfer; start stays high for a following item
  task automatic send(logic [2:0] fn, logic [15:0] off, logic [3:0] sz,
                      logic [63:0] din, logic hb, logic [15:0] vlen, logic lst);
    while ($urandom_range(99) < gap_pct) begin
      start = 0;
      @(negedge clk);
    end
    in_func = fn; in_offset = off; in_access_size = sz; in_data_in = din;
    in_has_byte = hb; in_value_len = vlen; in_last = lst;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note(fn, off, sz, din, hb, vlen, lst);
    items++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // key string from the pool, empty key when the pool entry has length 0
  task automatic send_key(int k);
    if (key_len_pool[k] == 0) begin
      send(FN_KEY, $urandom, $urandom, rnd64(), 1'b0, $urandom, 1'b1);
    end else begin
      for (int i = 0; i < key_len_pool[k]; i++)
        send(FN_KEY, $urandom, $urandom, {rnd64() >> 8, key_pool[k][i]}, 1'b1,
             $urandom, i == key_len_pool[k] - 1);
    end
  endtask

  // full set: key, then nbytes value bytes against a declared length
  task automatic do_set(int k, int vlen, int nbytes);
    send_key(k);
    if (nbytes == 0) begin
      send(FN_VALUE, $urandom, $urandom, rnd64(), 1'b0, vlen, 1'b1);
    end else begin
      for (int i = 0; i < nbytes; i++)
        send(FN_VALUE, $urandom, $urandom, rnd64(), 1'b1,
             (i == 0) ? vlen : $urandom, i == nbytes - 1);
    end
  endtask

  task automatic do_lookup(int k);
    send_key(k);
    send(FN_LOOKUP, $urandom, $urandom, rnd64(), $urandom, $urandom, $urandom);
  endtask

  // let all answers drain and the block settle
  task automatic drain();
    start = 0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_wen_cfg(logic v);
    drain();
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.wen = v;
  endtask

  // random traffic, mostly well-formed sets and lookups
  task automatic random_phase(int n_items);
    int stop;
    int sel;
    int vl;
    stop = items + n_items;
    while (items < stop) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        vl = $urandom_range(0, 12);
        if ($urandom_range(19) == 0) vl = $urandom_range(0, 65535);
        do_set($urandom_range(7), vl,
               ($urandom_range(3) == 0) ? $urandom_range(0, 14) : (vl > 14 ? 14 : vl));
      end else if (sel < 65) begin
        do_lookup($urandom_range(7));
      end else if (sel < 80) begin
        send(FN_BUS_RD, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 600),
             $urandom, rnd64(), $urandom, $urandom, $urandom);
      end else if (sel < 88) begin
        send(FN_BUS_WR, ($urandom_range(1) == 0) ? $urandom_range(4096, 8191) : $urandom,
             $urandom, rnd64(), $urandom, $urandom, $urandom);
      end else begin
        // noise and broken sequences: stray key/value items, unused codes
        send($urandom_range(2, 7), $urandom, $urandom, rnd64(), $urandom,
             $urandom_range(0, 20), $urandom);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < 8; k++) begin
      key_len_pool[k] = (k < 2) ? k : $urandom_range(1, 6);
      for (int i = 0; i < 6; i++) key_pool[k][i] = $urandom;
    end
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed: header, bus extremes, special set cases
    send(FN_BUS_RD, 16'd0, 4'd8, '0, 0, 0, 0);
    send(FN_BUS_RD, 16'd8188, 4'd15, '0, 0, 0, 0);
    send(FN_BUS_RD, 16'hFFFF, 4'd8, '0, 0, 0, 0);
    send(FN_BUS_RD, 16'd0, 4'd0, '0, 0, 0, 0);
    do_lookup(0);
    do_set(0, 0, 0);
    do_lookup(0);
    do_set(1, 5, 3);
    do_set(2, 2, 4);
    send(FN_BUS_WR, 16'd8190, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send(FN_BUS_WR, 16'd5000, 4'd15, 64'h0123_4567_89AB_CDEF, 0, 0, 0);
    send(FN_BUS_WR, 16'hFFFF, 4'd8, 64'h5555_AAAA_5555_AAAA, 0, 0, 0);
    send(FN_BUS_RD, 16'd8186, 4'd8, '0, 0, 0, 0);
    send(FN_BUS_RD, 16'd5000, 4'd8, '0, 0, 0, 0);
    send(5, 0, 0, '0, 0, 0, 0);
    send(6, 16'hFFFF, 4'hF, '1, 1, 16'hFFFF, 1);
    send(7, 0, 0, '0, 0, 0, 0);
    do_set(3, 16'hFFFF, 1);
    do_set(4, 300, 2);
    do_lookup(4);
    do_lookup(1);
    do_lookup(2);

    // random: three idling profiles, write enable turned off and back on
    gap_pct = 18;
    random_phase(20);
    set_wen_cfg(1'b0);
    gap_pct = 50;
    random_phase(20);
    set_wen_cfg(1'b1);
    gap_pct = 0;
    // long key saturates at its first 255 bytes
    for (int i = 0; i < 258; i++)
      send(FN_KEY, 0, 0, rnd64(), 1'b1, 0, i == 257);
    send(FN_VALUE, 0, 0, 64'hA5, 1'b1, 16'd1, 1'b1);
    send(FN_LOOKUP, 0, 0, '0, 0, 0, 0);
    random_phase(20);

    drain();
    $display("%0d transfers driven, %0d results checked, %0d lookup hits",
             items, sb.answers, sb.hits);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== key_value_log_store_top.f =====
rtl/kvls_pkg.sv
rtl/kvls_ram.sv
rtl/key_value_log_store_top.sv
rtl/kvls_checker.sv
tb/tb_key_value_log_store_top.sv
